[hdl/dq_pkg.sv]
// shared types and constants for the double-ended queue
`default_nettype none

package dq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 4;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int ENTRY_W    = 5;
	localparam int WORD_W     = 32;
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BOUNDS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// what the row of cells does this cycle
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_PUSH_FRONT,
		ACT_PUSH_BACK,
		ACT_POP_FRONT
	} act_t;

	// per-cell update
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	typedef struct packed {
		act_t             act;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] rd_idx;
	} chain_ctrl_t;

endpackage

`default_nettype wire

[hdl/dq_cell.sv]
// one storage cell of the queue row
`default_nettype none

module dq_cell (
	input  wire logic                           clk,
	input  wire dq_pkg::cell_op_t               op,
	input  wire logic                           rd_sel,
	input  wire logic [dq_pkg::DATA_WIDTH-1:0]  word,
	input  wire logic [dq_pkg::DATA_WIDTH-1:0]  left,
	input  wire logic [dq_pkg::DATA_WIDTH-1:0]  right,
	output logic      [dq_pkg::DATA_WIDTH-1:0]  data_q,
	output logic      [dq_pkg::DATA_WIDTH-1:0]  rd_data
);

	always_ff @(posedge clk) begin
		case (op)
			dq_pkg::CELL_LOAD:       data_q <= word;
			dq_pkg::CELL_FROM_LEFT:  data_q <= left;
			dq_pkg::CELL_FROM_RIGHT: data_q <= right;
			default:                 data_q <= data_q;
		endcase
	end

	// gated onto the read bus only when selected
	assign rd_data = rd_sel ? data_q : '0;

endmodule

`default_nettype wire

[hdl/dq_chain.sv]
// row of cells holding the queue, front entry in cell zero
`default_nettype none

module dq_chain (
	input  wire logic                           clk,
	input  wire dq_pkg::chain_ctrl_t            ctrl,
	input  wire logic [dq_pkg::DATA_WIDTH-1:0]  word,
	output logic      [dq_pkg::DATA_WIDTH-1:0]  rd_word
);

	logic [dq_pkg::DATA_WIDTH-1:0] cell_q  [dq_pkg::DEPTH];
	logic [dq_pkg::DATA_WIDTH-1:0] cell_rd [dq_pkg::DEPTH];

	for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
		dq_pkg::cell_op_t              op;
		logic                          rd_sel;
		logic [dq_pkg::DATA_WIDTH-1:0] left;
		logic [dq_pkg::DATA_WIDTH-1:0] right;

		if (i == 0) begin : g_first
			assign left = word;
		end else begin : g_mid
			assign left = cell_q[i-1];
		end

		if (i == dq_pkg::DEPTH - 1) begin : g_last
			assign right = cell_q[i];
		end else begin : g_inner
			assign right = cell_q[i+1];
		end

		assign rd_sel = (ctrl.rd_idx == dq_pkg::IDX_W'(i));

		always_comb begin
			case (ctrl.act)
				dq_pkg::ACT_PUSH_FRONT: op = (i == 0) ? dq_pkg::CELL_LOAD
				                                      : dq_pkg::CELL_FROM_LEFT;
				dq_pkg::ACT_PUSH_BACK:  op = (ctrl.count == dq_pkg::CNT_W'(i))
				                             ? dq_pkg::CELL_LOAD : dq_pkg::CELL_HOLD;
				dq_pkg::ACT_POP_FRONT:  op = dq_pkg::CELL_FROM_RIGHT;
				default:                op = dq_pkg::CELL_HOLD;
			endcase
		end

		dq_cell u_cell (
			.clk     (clk),
			.op      (op),
			.rd_sel  (rd_sel),
			.word    (word),
			.left    (left),
			.right   (right),
			.data_q  (cell_q[i]),
			.rd_data (cell_rd[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int k = 0; k < dq_pkg::DEPTH; k++) begin
			rd_word = rd_word | cell_rd[k];
		end
	end

endmodule

`default_nettype wire

[hdl/double_ended_queue_top.sv]
// double-ended queue: command decode, entry count and result register
// an accepted command's result word is registered and on the output the next cycle
// throughput: one command per cycle; a push shifts or loads the row of cells in one step
// input is stalled only while a result waits in the output register
// reset clears count_q and output valid; cell contents are undefined until pushed
`default_nettype none

module double_ended_queue_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [dq_pkg::CMD_W-1:0]      cmd,
	input  wire logic [dq_pkg::WORD_W-1:0]     push_data,
	input  wire logic [dq_pkg::POS_W-1:0]      position,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [dq_pkg::STATUS_W-1:0]   status,
	output logic      [dq_pkg::WORD_W-1:0]     read_data,
	output logic      [dq_pkg::ENTRY_W-1:0]    entry_count,
	output logic                               is_vacant
);

	logic                          accept;
	logic [dq_pkg::CNT_W-1:0]      count_q;
	logic [dq_pkg::CNT_W-1:0]      count_nxt;
	logic                          full;
	logic                          empty;
	logic                          in_range;
	dq_pkg::chain_ctrl_t           ctrl;
	dq_pkg::status_t               status_nxt;
	logic                          rd_use;
	logic [dq_pkg::DATA_WIDTH-1:0] word;
	logic [dq_pkg::DATA_WIDTH-1:0] rd_word;

	logic                          out_valid_q;
	dq_pkg::status_t               status_q;
	logic [dq_pkg::WORD_W-1:0]     read_data_q;
	logic [dq_pkg::CNT_W-1:0]      count_out_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign full     = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = (dq_pkg::CMP_W'(position) < dq_pkg::CMP_W'(count_q));
	assign word     = dq_pkg::DATA_WIDTH'(push_data);

	always_comb begin
		ctrl.act    = dq_pkg::ACT_NONE;
		ctrl.count  = count_q;
		ctrl.rd_idx = '0;
		status_nxt  = dq_pkg::ST_OK;
		rd_use      = 1'b0;
		count_nxt   = count_q;
		case (cmd)
			dq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_nxt = dq_pkg::ST_FULL;
				end else begin
					ctrl.act  = dq_pkg::ACT_PUSH_FRONT;
					count_nxt = count_q + 1'b1;
				end
			end
			dq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = dq_pkg::ST_FULL;
				end else begin
					ctrl.act  = dq_pkg::ACT_PUSH_BACK;
					count_nxt = count_q + 1'b1;
				end
			end
			dq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_nxt = dq_pkg::ST_EMPTY;
				end else begin
					ctrl.act  = dq_pkg::ACT_POP_FRONT;
					rd_use    = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			dq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_nxt = dq_pkg::ST_EMPTY;
				end else begin
					// back entry sits at count - 1; no shift needed
					ctrl.rd_idx = dq_pkg::IDX_W'(count_q - 1'b1);
					rd_use      = 1'b1;
					count_nxt   = count_q - 1'b1;
				end
			end
			dq_pkg::CMD_READ: begin
				if (!in_range) begin
					status_nxt = dq_pkg::ST_BOUNDS;
				end else begin
					ctrl.rd_idx = dq_pkg::IDX_W'(position);
					rd_use      = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctrl.act = dq_pkg::ACT_NONE;
		end
	end

	dq_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.word    (word),
		.rd_word (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			read_data_q <= rd_use ? dq_pkg::WORD_W'(rd_word) : '0;
			count_out_q <= count_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_data   = read_data_q;
	assign entry_count = dq_pkg::ENTRY_W'(count_out_q);
	assign is_vacant   = (count_out_q == '0);

endmodule

`default_nettype wire

[tb/dq_result_checker.sv]
// watches both channels of the double-ended queue, predicts each result word and compares
module dq_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [dq_pkg::CMD_W-1:0]      cmd,
	input  logic [dq_pkg::WORD_W-1:0]     push_data,
	input  logic [dq_pkg::POS_W-1:0]      position,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [dq_pkg::STATUS_W-1:0]   status,
	input  logic [dq_pkg::WORD_W-1:0]     read_data,
	input  logic [dq_pkg::ENTRY_W-1:0]    entry_count,
	input  logic                          is_vacant,
	output int                            pending,
	output int                            mismatches
);
	import dq_pkg::*;

	typedef struct packed {
		status_t            st;
		logic [WORD_W-1:0]  word;
		logic [ENTRY_W-1:0] count;
		logic               vacant;
	} dq_outcome_t;

	// shadow copy of the ring
	logic [WORD_W-1:0] ring [DEPTH];
	logic [IDX_W-1:0]  head;
	logic [CNT_W-1:0]  fill;

	dq_outcome_t outcomes_due[$];
	int          fault_count;

	function automatic dq_outcome_t deque_outcome(logic [CMD_W-1:0] op, logic [WORD_W-1:0] w,
			logic [POS_W-1:0] pos);
		dq_outcome_t      r;
		logic [IDX_W-1:0] idx;
		r.st = ST_OK;
		r.word = '0;
		case (op)
			CMD_PUSH_FRONT: begin
				if (fill == DEPTH) begin
					r.st = ST_FULL;
				end else begin
					head = head - 1'b1;
					ring[head] = w;
					fill = fill + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (fill == DEPTH) begin
					r.st = ST_FULL;
				end else begin
					idx = head + fill[IDX_W-1:0];
					ring[idx] = w;
					fill = fill + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.word = ring[head];
					head = head + 1'b1;
					fill = fill - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					fill = fill - 1'b1;
					idx = head + fill[IDX_W-1:0];
					r.word = ring[idx];
				end
			end
			CMD_READ: begin
				if ({1'b0, pos} >= fill) begin
					r.st = ST_BOUNDS;
				end else begin
					idx = head + pos;
					r.word = ring[idx];
				end
			end
			default: ; // spare codes leave the queue alone
		endcase
		r.count = fill;
		r.vacant = (fill == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dq_outcome_t e;
		if (!arst_n) begin
			head = '0;
			fill = '0;
			fault_count = 0;
			outcomes_due.delete();
			pending <= 0;
			mismatches <= 0;
		end else begin
			// result first: it belongs to an earlier command
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: result word with nothing expected (status %0d data %h count %0d)",
						$time, status, read_data, entry_count);
					fault_count++;
				end else begin
					e = outcomes_due[0];
					outcomes_due.delete(0);
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						fault_count++;
					end
					if (read_data !== e.word) begin
						$display("%0t: read_data expected %h actual %h", $time, e.word, read_data);
						fault_count++;
					end
					if (entry_count !== e.count) begin
						$display("%0t: entry_count expected %0d actual %0d", $time, e.count,
							entry_count);
						fault_count++;
					end
					if (is_vacant !== e.vacant) begin
						$display("%0t: is_vacant expected %0d actual %0d", $time, e.vacant,
							is_vacant);
						fault_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				outcomes_due.push_back(deque_outcome(cmd, push_data, position));
			pending <= outcomes_due.size();
			mismatches <= fault_count;
		end
	end

endmodule

[tb/testbench.sv]
// stimulus and verdict for the double-ended queue, with the result checker beside the block
module testbench;
	import dq_pkg::*;

	localparam logic [CMD_W-1:0] SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] SPARE_LAST  = 3'd7;
	localparam int LEAN_FILL  = 0;
	localparam int LEAN_DRAIN = 1;
	localparam int LEAN_MIXED = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 out_stall = 1'b0;
	logic [CMD_W-1:0]     cmd = '0;
	logic [WORD_W-1:0]    push_data = '0;
	logic [POS_W-1:0]     position = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic [STATUS_W-1:0]  status;
	logic [WORD_W-1:0]    read_data;
	logic [ENTRY_W-1:0]   entry_count;
	logic                 is_vacant;
	int                   pending;
	int                   mismatches;
	int                   stall_run = 0;

	always #5 clk = ~clk;

	double_ended_queue_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .push_data(push_data), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .read_data(read_data), .entry_count(entry_count), .is_vacant(is_vacant)
	);

	dq_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .push_data(push_data), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .read_data(read_data), .entry_count(entry_count), .is_vacant(is_vacant),
		.pending(pending), .mismatches(mismatches)
	);

	// receiver: short stalls, short runs, occasional long stall or long quiet stretch
	always @(posedge clk) begin
		int r;
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(0, 8);
			end else if (r < 85) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(0, 2);
			end else if (r < 95) begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(30, 120);
			end else begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(10, 30);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return POS_W'($urandom_range(0, 3));
		else if (r < 90)
			return POS_W'($urandom_range(0, DEPTH - 1));
		return POS_W'(DEPTH - 1);
	endfunction

	// lean steers the fill level so full and empty both come up often
	function automatic logic [CMD_W-1:0] pick_op(int lean);
		int r;
		int push_cut;
		int pop_cut;
		r = $urandom_range(0, 99);
		push_cut = (lean == LEAN_FILL) ? 70 : (lean == LEAN_DRAIN) ? 15 : 40;
		pop_cut = (lean == LEAN_FILL) ? 85 : (lean == LEAN_DRAIN) ? 85 : 75;
		if (r < push_cut)
			return (r % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		else if (r < pop_cut)
			return (r % 2) ? CMD_POP_BACK : CMD_POP_FRONT;
		else if (r < 97)
			return CMD_READ;
		return CMD_W'($urandom_range(SPARE_FIRST, SPARE_LAST));
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] w,
			input logic [POS_W-1:0] pos, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		push_data <= w;
		position <= pos;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the sender until every result word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int lean;
		bit burst;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: both pops and a read refused, then a push at each end and two reads
		send_word(CMD_POP_FRONT, pick_word(), '0, 1'b0);
		send_word(CMD_POP_BACK, pick_word(), '0, 1'b0);
		send_word(CMD_READ, pick_word(), '0, 1'b0);
		send_word(CMD_PUSH_BACK, '0, '0, 1'b0);
		send_word(CMD_PUSH_FRONT, '1, '0, 1'b0);
		send_word(CMD_READ, '0, 4'd1, 1'b0);
		send_word(CMD_READ, '0, 4'd2, 1'b0);
		// fill to the brim, then push at both ends
		for (int i = 0; i < DEPTH - 2; i++)
			send_word((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom, '0, 1'b0);
		send_word(CMD_PUSH_FRONT, $urandom, '0, 1'b0);
		send_word(CMD_PUSH_BACK, $urandom, '0, 1'b0);
		send_word(CMD_READ, '0, POS_W'(DEPTH - 1), 1'b0);
		for (int c = SPARE_FIRST; c <= SPARE_LAST; c++)
			send_word(CMD_W'(c), '1, '1, 1'b0);
		drain_results();

		for (int blk = 0; blk < 16; blk++) begin
			lean = $urandom_range(LEAN_FILL, LEAN_MIXED);
			burst = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < 25; i++)
				send_word(pick_op(lean), pick_word(), pick_position(), burst);
			if (blk == 7)
				drain_results();
		end

		drain_results();
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

[double_ended_queue_top.f]
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/dq_chain.sv
hdl/double_ended_queue_top.sv
tb/dq_result_checker.sv
tb/testbench.sv
